// ===== design/avgp_pkg.sv =====
`default_nettype none
package avgp_pkg;

    // image and window limits
    localparam int MAX_COLS     = 64;
    localparam int MAX_ROWS     = 64;
    localparam int MAX_CHANNELS = 16;
    localparam int MAX_WINDOW   = 8;
    localparam int RESULT_CAP   = 64;

    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int CH_W    = $clog2(MAX_CHANNELS);
    localparam int WIN_W   = $clog2(MAX_WINDOW);
    localparam int STORE_DEPTH = MAX_WINDOW * MAX_ROWS * MAX_CHANNELS;
    localparam int ADDR_W  = $clog2(STORE_DEPTH);

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 23;
    localparam int MAG_W    = 22;
    localparam int CNT_W    = 7;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_ADDR_W-1:0] CFG_IN_COLS   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IN_ROWS   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHANNELS  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIN_COLS  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIN_ROWS  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_COLS = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_ROWS = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAME_PAD  = 3'd7;

    // one pooled result
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic [COL_W-1:0]           col;
        logic [ROW_W-1:0]           row;
        logic [CH_W-1:0]            channel;
        logic                       empty;
    } t_result;

endpackage
`default_nettype wire

// ===== design/avgp_ram.sv =====
`default_nettype none
module avgp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== design/avg_pooling_2d.sv =====
`default_nettype none
// Streaming 2-D average pooling, padding excluded from the count. Samples
// arrive channel fastest, then row, then column; the last 8 columns live in
// an 8192 x 16 RAM with a registered read port. One request is taken at a time.
// After any configuration write (and after reset) a geometry pass holds stall
// high. Each request then passes through accept, a scan over the output
// columns (under a matching column, a scan over the output rows that closes
// with a row-scan end), the end of the column scan and a flush. Every
// produced result adds one RAM read per in-bounds window sample (one per
// cycle, set by the single read port), then sum drain, divider setup, the
// bit-serial divide and a hand-off that waits while the output is stalled.
// A result waits in a holding register so that the final one of a request
// can carry the last flag.
module avg_pooling_2d (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input requests
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic signed [avgp_pkg::SAMPLE_W-1:0] i_sample,
    // result requests
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic signed [avgp_pkg::SAMPLE_W-1:0]  o_average,
    output logic [avgp_pkg::COL_W-1:0]            o_out_col,
    output logic [avgp_pkg::ROW_W-1:0]            o_out_row,
    output logic [avgp_pkg::CH_W-1:0]             o_out_channel,
    output logic                                  o_empty_window,
    output logic                                  o_last,
    // configuration
    input  wire logic                             i_cfg_we,
    input  wire logic [avgp_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [avgp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import avgp_pkg::*;

    typedef enum logic [3:0] {
        S_GEO, S_IDLE, S_JSCAN, S_KSCAN, S_SUM, S_SUMEND, S_PREP, S_DIV, S_PUSH, S_FLUSH
    } t_state;

    t_state r_state;

    // clamped configuration
    logic [6:0] r_ic, r_ir;
    logic [4:0] r_nch;
    logic [3:0] r_wc, r_wr, r_sc, r_sr;
    logic       r_same;

    // geometry
    logic [6:0] r_oc, r_or;
    logic [3:0] r_pc, r_pr;
    logic [7:0] r_gs_c, r_gs_r, r_glast_c, r_glast_r;
    logic       r_gdone_c, r_gdone_r;

    // image position
    logic [COL_W-1:0] r_pos_c, r_cur_c;
    logic [ROW_W-1:0] r_pos_r, r_cur_r;
    logic [CH_W-1:0]  r_pos_ch, r_cur_ch;

    // window scan
    logic [6:0]         r_j, r_k, r_n;
    logic signed [11:0] r_cs, r_rs;
    logic [6:0]         r_clo, r_chi, r_rlo, r_rhi;
    logic [5:0]         r_a, r_b;

    // sum and divide
    logic               r_rd_vld;
    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]   r_cnt;
    logic [MAG_W-1:0]   r_dq;
    logic [6:0]         r_rem;
    logic [4:0]         r_dcnt;
    logic               r_neg;

    // result holding and output registers
    t_result r_pend, r_out;
    logic    r_pend_vld, r_out_vld, r_out_last;

    logic [SAMPLE_W-1:0] ram_rdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic                in_acc, out_free, out_load;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_vld || !i_out_stall;
    assign ram_raddr = {r_a[WIN_W-1:0], r_b, r_cur_ch};
    // holding register moves to the output register this cycle
    assign out_load = !i_cfg_we && r_pend_vld && out_free
                      && ((r_state == S_PUSH) || (r_state == S_FLUSH));

    avgp_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr ({r_pos_c[WIN_W-1:0], r_pos_r, r_pos_ch}),
        .i_wdata (i_sample),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // geometry pass: count window starts along each axis and the same-padding offsets
    logic [8:0] g_end_c, g_end_r;
    logic       g_fit_c, g_fit_r;
    logic signed [9:0] g_t_c, g_t_r;
    logic [3:0] g_pc, g_pr;

    always_comb begin
        g_end_c = {1'b0, r_gs_c} + {5'b0, r_wc};
        g_end_r = {1'b0, r_gs_r} + {5'b0, r_wr};
        g_fit_c = r_same ? (r_gs_c < {1'b0, r_ic}) : (g_end_c <= {2'b0, r_ic});
        g_fit_r = r_same ? (r_gs_r < {1'b0, r_ir}) : (g_end_r <= {2'b0, r_ir});
        g_t_c = $signed({2'b0, r_glast_c}) + $signed({6'b0, r_wc}) - $signed({3'b0, r_ic});
        g_t_r = $signed({2'b0, r_glast_r}) + $signed({6'b0, r_wr}) - $signed({3'b0, r_ir});
        g_pc = (!r_same || r_oc == 7'd0 || g_t_c < 0) ? 4'd0 : {1'b0, g_t_c[3:1]};
        g_pr = (!r_same || r_or == 7'd0 || g_t_r < 0) ? 4'd0 : {1'b0, g_t_r[3:1]};
    end

    // in-bounds extent of the current column and row windows
    logic signed [11:0] ce, clo, chi, re, rlo, rhi;
    logic               match_c, match_r;

    always_comb begin
        ce  = r_cs + $signed({8'b0, r_wc});
        clo = (r_cs < 0) ? 12'sd0 : r_cs;
        chi = (ce > $signed({5'b0, r_ic})) ? $signed({5'b0, r_ic}) : ce;
        match_c = (clo < chi) && (chi == $signed({6'b0, r_cur_c}) + 12'sd1);
        re  = r_rs + $signed({8'b0, r_wr});
        rlo = (r_rs < 0) ? 12'sd0 : r_rs;
        rhi = (re > $signed({5'b0, r_ir})) ? $signed({5'b0, r_ir}) : re;
        match_r = (rlo < rhi) && (rhi == $signed({6'b0, r_cur_r}) + 12'sd1);
    end

    // one restoring divide step
    logic [7:0] d_sh;
    logic       d_ge;
    logic [7:0] d_sub;

    always_comb begin
        d_sh  = {r_rem, r_dq[MAG_W-1]};
        d_ge  = d_sh >= {1'b0, r_cnt};
        d_sub = d_sh - {1'b0, r_cnt};
    end

    // assembled result
    t_result new_res;

    always_comb begin
        new_res.average = (r_cnt == '0) ? '0
                        : (r_neg ? $signed(~r_dq[SAMPLE_W-1:0] + 16'd1)
                                 : $signed(r_dq[SAMPLE_W-1:0]));
        new_res.col     = r_j[COL_W-1:0];
        new_res.row     = r_k[ROW_W-1:0];
        new_res.channel = r_cur_ch;
        new_res.empty   = (r_cnt == '0);
    end

    // sum magnitude for the divider
    logic [SUM_W-1:0] sum_mag;
    assign sum_mag = r_sum[SUM_W-1] ? (~r_sum + 23'd1) : r_sum;

    // control and data path
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_GEO;
            r_ic       <= 7'd1;
            r_ir       <= 7'd1;
            r_nch      <= 5'd1;
            r_wc       <= 4'd1;
            r_wr       <= 4'd1;
            r_sc       <= 4'd1;
            r_sr       <= 4'd1;
            r_same     <= 1'b0;
            r_gs_c     <= '0;
            r_gs_r     <= '0;
            r_oc       <= '0;
            r_or       <= '0;
            r_gdone_c  <= 1'b0;
            r_gdone_r  <= 1'b0;
            r_pos_c    <= '0;
            r_pos_r    <= '0;
            r_pos_ch   <= '0;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            // output register loads or drains
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end

            // accumulate the read issued last cycle
            r_rd_vld <= (r_state == S_SUM);
            if (r_rd_vld) begin
                r_sum <= r_sum + {{(SUM_W-SAMPLE_W){ram_rdata[SAMPLE_W-1]}}, ram_rdata};
                r_cnt <= r_cnt + 7'd1;
            end

            if (i_cfg_we) begin
                // register write restarts the image and the geometry pass
                unique case (i_cfg_addr)
                    CFG_IN_COLS: r_ic <= (i_cfg_data == '0) ? 7'd1
                        : (i_cfg_data > 7'd64) ? 7'd64 : i_cfg_data;
                    CFG_IN_ROWS: r_ir <= (i_cfg_data == '0) ? 7'd1
                        : (i_cfg_data > 7'd64) ? 7'd64 : i_cfg_data;
                    CFG_CHANNELS: r_nch <= (i_cfg_data[4:0] == '0) ? 5'd1
                        : (i_cfg_data[4:0] > 5'd16) ? 5'd16 : i_cfg_data[4:0];
                    CFG_WIN_COLS: r_wc <= (i_cfg_data[3:0] == '0) ? 4'd1
                        : (i_cfg_data[3:0] > 4'd8) ? 4'd8 : i_cfg_data[3:0];
                    CFG_WIN_ROWS: r_wr <= (i_cfg_data[3:0] == '0) ? 4'd1
                        : (i_cfg_data[3:0] > 4'd8) ? 4'd8 : i_cfg_data[3:0];
                    CFG_STEP_COLS: r_sc <= (i_cfg_data[3:0] == '0) ? 4'd1 : i_cfg_data[3:0];
                    CFG_STEP_ROWS: r_sr <= (i_cfg_data[3:0] == '0) ? 4'd1 : i_cfg_data[3:0];
                    CFG_SAME_PAD: r_same <= i_cfg_data[0];
                    default: ;
                endcase
                r_pos_c   <= '0;
                r_pos_r   <= '0;
                r_pos_ch  <= '0;
                r_gs_c    <= '0;
                r_gs_r    <= '0;
                r_oc      <= '0;
                r_or      <= '0;
                r_gdone_c <= 1'b0;
                r_gdone_r <= 1'b0;
                r_state   <= S_GEO;
            end else begin
                unique case (r_state)
                    S_GEO: begin
                        if (!r_gdone_c) begin
                            if (g_fit_c) begin
                                r_oc      <= r_oc + 7'd1;
                                r_glast_c <= r_gs_c;
                                r_gs_c    <= r_gs_c + {4'b0, r_sc};
                            end else begin
                                r_gdone_c <= 1'b1;
                            end
                        end
                        if (!r_gdone_r) begin
                            if (g_fit_r) begin
                                r_or      <= r_or + 7'd1;
                                r_glast_r <= r_gs_r;
                                r_gs_r    <= r_gs_r + {4'b0, r_sr};
                            end else begin
                                r_gdone_r <= 1'b1;
                            end
                        end
                        if (r_gdone_c && r_gdone_r) begin
                            r_pc    <= g_pc;
                            r_pr    <= g_pr;
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (in_acc) begin
                            r_cur_c  <= r_pos_c;
                            r_cur_r  <= r_pos_r;
                            r_cur_ch <= r_pos_ch;
                            // advance channel, row, column
                            if ({1'b0, r_pos_ch} + 5'd1 >= r_nch) begin
                                r_pos_ch <= '0;
                                if ({1'b0, r_pos_r} + 7'd1 >= r_ir) begin
                                    r_pos_r <= '0;
                                    if ({1'b0, r_pos_c} + 7'd1 >= r_ic) begin
                                        r_pos_c <= '0;
                                    end else begin
                                        r_pos_c <= r_pos_c + 6'd1;
                                    end
                                end else begin
                                    r_pos_r <= r_pos_r + 6'd1;
                                end
                            end else begin
                                r_pos_ch <= r_pos_ch + 4'd1;
                            end
                            r_j     <= '0;
                            r_cs    <= -$signed({8'b0, r_pc});
                            r_n     <= '0;
                            r_state <= S_JSCAN;
                        end
                    end
                    S_JSCAN: begin
                        if (r_j >= r_oc) begin
                            r_state <= S_FLUSH;
                        end else if (match_c) begin
                            r_clo   <= clo[6:0];
                            r_chi   <= chi[6:0];
                            r_k     <= '0;
                            r_rs    <= -$signed({8'b0, r_pr});
                            r_state <= S_KSCAN;
                        end else begin
                            r_j  <= r_j + 7'd1;
                            r_cs <= r_cs + $signed({8'b0, r_sc});
                        end
                    end
                    S_KSCAN: begin
                        if (r_k >= r_or) begin
                            r_j     <= r_j + 7'd1;
                            r_cs    <= r_cs + $signed({8'b0, r_sc});
                            r_state <= S_JSCAN;
                        end else if (match_r && (r_n < 7'(RESULT_CAP))) begin
                            r_rlo   <= rlo[6:0];
                            r_rhi   <= rhi[6:0];
                            r_a     <= clo[5:0];
                            r_b     <= rlo[5:0];
                            r_sum   <= '0;
                            r_cnt   <= '0;
                            r_state <= S_SUM;
                        end else begin
                            r_k  <= r_k + 7'd1;
                            r_rs <= r_rs + $signed({8'b0, r_sr});
                        end
                    end
                    S_SUM: begin
                        // walk rows inside columns, one read a cycle
                        if ({1'b0, r_b} + 7'd1 == r_rhi) begin
                            r_b <= r_rlo[5:0];
                            if ({1'b0, r_a} + 7'd1 == r_chi) begin
                                r_state <= S_SUMEND;
                            end else begin
                                r_a <= r_a + 6'd1;
                            end
                        end else begin
                            r_b <= r_b + 6'd1;
                        end
                    end
                    S_SUMEND: begin
                        r_state <= S_PREP;
                    end
                    S_PREP: begin
                        r_neg   <= r_sum[SUM_W-1];
                        r_dq    <= sum_mag[MAG_W-1:0];
                        r_rem   <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end
                    S_DIV: begin
                        r_rem  <= d_ge ? d_sub[6:0] : d_sh[6:0];
                        r_dq   <= {r_dq[MAG_W-2:0], d_ge};
                        r_dcnt <= r_dcnt + 5'd1;
                        if (r_dcnt == 5'(MAG_W - 1)) begin
                            r_state <= S_PUSH;
                        end
                    end
                    S_PUSH: begin
                        if (!r_pend_vld || out_free) begin
                            if (r_pend_vld) begin
                                r_out      <= r_pend;
                                r_out_last <= 1'b0;
                            end
                            r_pend     <= new_res;
                            r_pend_vld <= 1'b1;
                            r_n        <= r_n + 7'd1;
                            r_k        <= r_k + 7'd1;
                            r_rs       <= r_rs + $signed({8'b0, r_sr});
                            r_state    <= S_KSCAN;
                        end
                    end
                    S_FLUSH: begin
                        // final result of the request carries last
                        if (!r_pend_vld) begin
                            r_state <= S_IDLE;
                        end else if (out_free) begin
                            r_out      <= r_pend;
                            r_out_last <= 1'b1;
                            r_pend_vld <= 1'b0;
                            r_state    <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_vld;
    assign o_average      = r_out.average;
    assign o_out_col      = r_out.col;
    assign o_out_row      = r_out.row;
    assign o_out_channel  = r_out.channel;
    assign o_empty_window = r_out.empty;
    assign o_last         = r_out_last;

endmodule
`default_nettype wire
